>>> rtl/ssi_pkg.sv
// Shared constants and types for the selection sort block.
// No dependencies; imported by selection_sort_integer_top.
package ssi_pkg;

	// Store depth and stored value width
	localparam int MAX_ITEMS  = 64;
	localparam int DATA_WIDTH = 32;

	// Derived widths
	localparam int IDX_W = $clog2(MAX_ITEMS);
	localparam int EXT_W = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

	// Configuration register byte addresses
	localparam logic [2:0] REG_COMPARE_SIGNED = 3'd0;

	typedef logic [DATA_WIDTH-1:0] data_t;
	typedef logic [IDX_W-1:0]      idx_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_LOAD,
		S_RDPOS,
		S_CAP,
		S_SCAN,
		S_SWAP1,
		S_SWAP2,
		S_ERD,
		S_EWAIT
	} state_t;

	// Memory port controls from the sequencer
	typedef struct packed {
		logic  we;
		idx_t  waddr;
		data_t wdata;
		logic  re;
		idx_t  raddr;
	} mem_ctl_t;

endpackage

>>> rtl/selection_sort_integer_top.sv
// Selection sort block: load store, sequencer, shared comparator and output register.
// Depends on ssi_pkg.
//
// Values are loaded one item per cycle into a store with one write port and one read port
// until an item marked last arrives or the store fills. The run of n values is then sorted
// in place by one comparator that scans the unsorted tail through the store's read port.
// Each result is then read from the store and loaded into the output register once the
// previous result has been taken. in_ready is low from the end of a run until its last
// result is in the output register; the next run loads while that result waits to be
// taken. The compare mode in effect when a run completes governs its whole sort.
module selection_sort_integer_top (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] element_value,
	input  logic        is_last,
	// Output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] sorted_value,
	output logic        last_of_run
);
	import ssi_pkg::*;

	state_t   state_q, state_d;
	mem_ctl_t mem_ctl;

	logic  compare_signed_q;
	logic  mode_q;
	idx_t  cnt_q;
	idx_t  last_idx_q;
	idx_t  pos_q;
	idx_t  cidx_q;
	idx_t  best_idx_q;
	idx_t  eidx_q;
	data_t best_val_q;
	data_t pos_val_q;
	data_t rd_q;
	data_t in_val;
	idx_t  pos_inc;
	idx_t  cidx_inc;
	logic  accept;
	logic  run_done;
	logic  less;
	logic  out_load;
	logic  out_valid_q;
	logic  out_last_q;
	logic [31:0] out_data_q;

	data_t mem [MAX_ITEMS];

	// Configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compare_signed_q <= 1'b1;
		end else if (psel && penable && pwrite && paddr[2] == REG_COMPARE_SIGNED[2]) begin
			compare_signed_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_COMPARE_SIGNED[2]) begin
			prdata[0] = compare_signed_q;
		end
	end

	// Input handling
	assign in_val   = DATA_WIDTH'(EXT_W'(element_value));
	assign accept   = in_valid && in_ready;
	assign run_done = is_last || (cnt_q == idx_t'(MAX_ITEMS - 1));
	assign pos_inc  = pos_q + 1'b1;
	assign cidx_inc = cidx_q + 1'b1;

	// Shared comparator: candidate orders strictly before current best
	always_comb begin
		data_t a;
		data_t b;
		a = rd_q;
		b = best_val_q;
		if (mode_q) begin
			a[DATA_WIDTH-1] = ~a[DATA_WIDTH-1];
			b[DATA_WIDTH-1] = ~b[DATA_WIDTH-1];
		end
		less = a < b;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_LOAD: begin
				if (accept && run_done) begin
					state_d = (cnt_q == '0) ? S_ERD : S_RDPOS;
				end
			end
			S_RDPOS: state_d = S_CAP;
			S_CAP:   state_d = S_SCAN;
			S_SCAN: begin
				if (cidx_q == last_idx_q) begin
					state_d = S_SWAP1;
				end
			end
			S_SWAP1: state_d = S_SWAP2;
			S_SWAP2: state_d = (pos_inc < last_idx_q) ? S_RDPOS : S_ERD;
			S_ERD:   state_d = S_EWAIT;
			S_EWAIT: begin
				if (out_load) begin
					state_d = (eidx_q == last_idx_q) ? S_LOAD : S_ERD;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	// Sequencer outputs: handshake and store port
	always_comb begin
		in_ready      = 1'b0;
		out_load      = 1'b0;
		mem_ctl.we    = 1'b0;
		mem_ctl.waddr = cnt_q;
		mem_ctl.wdata = in_val;
		mem_ctl.re    = 1'b0;
		mem_ctl.raddr = pos_q;
		unique case (state_q)
			S_LOAD: begin
				in_ready   = 1'b1;
				mem_ctl.we = accept;
			end
			S_RDPOS: begin
				mem_ctl.re = 1'b1;
			end
			S_CAP: begin
				mem_ctl.re    = 1'b1;
				mem_ctl.raddr = pos_inc;
			end
			S_SCAN: begin
				mem_ctl.re    = cidx_q != last_idx_q;
				mem_ctl.raddr = cidx_inc;
			end
			S_SWAP1: begin
				mem_ctl.we    = 1'b1;
				mem_ctl.waddr = best_idx_q;
				mem_ctl.wdata = pos_val_q;
			end
			S_SWAP2: begin
				mem_ctl.we    = 1'b1;
				mem_ctl.waddr = pos_q;
				mem_ctl.wdata = best_val_q;
			end
			S_ERD: begin
				mem_ctl.re    = 1'b1;
				mem_ctl.raddr = eidx_q;
			end
			S_EWAIT: begin
				out_load = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// Value store with registered read
	always_ff @(posedge clk) begin
		if (mem_ctl.we) begin
			mem[mem_ctl.waddr] <= mem_ctl.wdata;
		end
		if (mem_ctl.re) begin
			rd_q <= mem[mem_ctl.raddr];
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			cnt_q      <= '0;
			last_idx_q <= '0;
			pos_q      <= '0;
			cidx_q     <= '0;
			best_idx_q <= '0;
			eidx_q     <= '0;
			mode_q     <= 1'b1;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_LOAD: begin
					// Count the item; close the run on last or full
					if (accept) begin
						if (run_done) begin
							cnt_q      <= '0;
							last_idx_q <= cnt_q;
							mode_q     <= compare_signed_q;
							pos_q      <= '0;
							eidx_q     <= '0;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				S_CAP: begin
					best_idx_q <= pos_q;
					cidx_q     <= pos_inc;
				end
				S_SCAN: begin
					if (less) begin
						best_idx_q <= cidx_q;
					end
					if (cidx_q != last_idx_q) begin
						cidx_q <= cidx_inc;
					end
				end
				S_SWAP2: begin
					pos_q  <= pos_inc;
					eidx_q <= '0;
				end
				S_EWAIT: begin
					if (out_load) begin
						eidx_q <= eidx_q + 1'b1;
					end
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	// Best value and tail head, payload only
	always_ff @(posedge clk) begin
		if (state_q == S_CAP) begin
			best_val_q <= rd_q;
			pos_val_q  <= rd_q;
		end else if (state_q == S_SCAN && less) begin
			best_val_q <= rd_q;
		end
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= 32'(EXT_W'(rd_q));
			out_last_q <= eidx_q == last_idx_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign sorted_value = out_data_q;
	assign last_of_run  = out_last_q;

	// Checks
	a_last_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_last) |=> !in_ready)
		else $error("input still ready after a run closed");

	a_scan_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (cidx_q > pos_q && cidx_q <= last_idx_q
			&& best_idx_q >= pos_q && best_idx_q <= cidx_q))
		else $error("scan index out of the unsorted tail");

	a_run_end_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && eidx_q == last_idx_q) |=> (state_q == S_LOAD && cnt_q == '0
			&& out_valid && last_of_run))
		else $error("run end did not return to load with an empty store");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RDPOS) |-> (pos_q < last_idx_q))
		else $error("selection pass started past the last position");

endmodule

>>> tb/selection_sort_integer_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the selection sort block: watches the config, input and output channels.
// Predicts each sorted run and compares every result item. Depends on ssi_pkg.
module selection_sort_integer_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] element_value,
	input  logic        is_last,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] sorted_value,
	input  logic        last_of_run,
	output int          fail_count,
	output int          outstanding,
	output int          runs_seen,
	output int          results_seen
);
	import ssi_pkg::*;

	typedef struct packed {
		logic [31:0] value;
		logic        last;
	} sorted_item_t;

	sorted_item_t sorted_q[$];
	sorted_item_t got_item;
	data_t        run_buf[MAX_ITEMS];
	int           run_len;
	logic         signed_order;

	// True when a orders strictly ahead of b under the current compare mode
	function automatic logic precedes(data_t a, data_t b, logic sgn);
		if (sgn) begin
			return $signed(a) < $signed(b);
		end
		return a < b;
	endfunction

	// Sort the collected run in place and queue its values, last one marked
	task automatic queue_sorted_run();
		int    pos;
		int    k;
		int    best;
		data_t held;
		sorted_item_t item;
		for (pos = 0; pos + 1 < run_len; pos++) begin
			best = pos;
			for (k = pos + 1; k < run_len; k++) begin
				if (precedes(run_buf[k], run_buf[best], signed_order)) begin
					best = k;
				end
			end
			held          = run_buf[pos];
			run_buf[pos]  = run_buf[best];
			run_buf[best] = held;
		end
		for (k = 0; k < run_len; k++) begin
			item.value = run_buf[k];
			item.last  = (k == run_len - 1);
			sorted_q.push_back(item);
		end
		run_len = 0;
		runs_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_order = 1'b1;
			run_len      = 0;
			sorted_q.delete();
			fail_count   = 0;
			outstanding  = 0;
			runs_seen    = 0;
			results_seen = 0;
		end else begin
			// Track the compare mode; other addresses are ignored
			if (psel && penable && pwrite && pready && paddr == REG_COMPARE_SIGNED) begin
				signed_order = pwdata[0];
			end
			// Compare each result item with the oldest prediction
			if (out_valid && out_ready) begin
				results_seen++;
				if (sorted_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%0t: result %h last %b with nothing expected",
							$realtime, sorted_value, last_of_run);
					end
				end else begin
					got_item = sorted_q.pop_front();
					if (sorted_value !== got_item.value || last_of_run !== got_item.last) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: expected value %h last %b, got value %h last %b",
								$realtime, got_item.value, got_item.last,
								sorted_value, last_of_run);
						end
					end
				end
			end
			// Collect input items; a marked item or a full store closes the run
			if (in_valid && in_ready) begin
				run_buf[run_len] = element_value[DATA_WIDTH-1:0];
				run_len++;
				if (is_last || run_len == MAX_ITEMS) begin
					queue_sorted_run();
				end
			end
			outstanding = sorted_q.size();
		end
	end

endmodule

>>> tb/selection_sort_integer_top_tb.sv
`timescale 1ns / 1ps
// Top of the selection sort testbench: clock, reset, config writes, item traffic, verdict.
// Depends on ssi_pkg, selection_sort_integer_top and selection_sort_integer_checker.
module selection_sort_integer_top_tb;
	import ssi_pkg::*;

	localparam logic [2:0] ADDR_UNUSED  = 3'd4;
	localparam int         HOLD_CYCLES  = 2000;
	localparam int         DRAIN_CYCLES = 40;
	localparam int         TIMEOUT_NS   = 8000000;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] element_value;
	logic        is_last;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] sorted_value;
	logic        last_of_run;

	int   fail_count;
	int   outstanding;
	int   runs_seen;
	int   results_seen;
	int   items_sent;
	int   send_idle_pct;
	int   recv_stall_pct;
	logic pressure_req;
	logic hold_done;
	int   hold_count;

	always #4 clk = ~clk;

	selection_sort_integer_top dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.element_value(element_value), .is_last(is_last),
		.out_valid(out_valid), .out_ready(out_ready),
		.sorted_value(sorted_value), .last_of_run(last_of_run)
	);

	selection_sort_integer_checker sort_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.element_value(element_value), .is_last(is_last),
		.out_valid(out_valid), .out_ready(out_ready),
		.sorted_value(sorted_value), .last_of_run(last_of_run),
		.fail_count(fail_count), .outstanding(outstanding),
		.runs_seen(runs_seen), .results_seen(results_seen)
	);

	// Hard stop in case the block hangs
	initial begin
		#(TIMEOUT_NS);
		$display("Some tests failed");
		$finish;
	end

	// Output side: random stalls, plus one long hold-off when requested
	initial begin
		hold_done  = 1'b0;
		hold_count = 0;
		out_ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (pressure_req && !hold_done) begin
				out_ready <= 1'b0;
				hold_count++;
				if (hold_count >= HOLD_CYCLES) begin
					hold_done = 1'b1;
				end
			end else begin
				out_ready <= !(recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	// APB write: setup phase, then access phase until pready
	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one item, optionally after idle cycles, and hold it until accepted
	task automatic send_value(input logic [31:0] value, input logic mark);
		if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid      <= 1'b1;
		element_value <= value;
		is_last       <= mark;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	// Drop valid and let every predicted result drain before touching config
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Run mixing both sign boundaries, zero and all ones
	task automatic send_extremes_run();
		send_value(32'h7FFF_FFFF, 1'b0);
		send_value(32'h8000_0000, 1'b0);
		send_value(32'h0000_0000, 1'b0);
		send_value(32'hFFFF_FFFF, 1'b0);
		send_value(32'h0000_0001, 1'b0);
		send_value(32'h8000_0001, 1'b1);
	endtask

	// Value mix that favors boundaries and duplicates
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: pick_value = 32'h0000_0000;
			1: pick_value = 32'hFFFF_FFFF;
			2: pick_value = 32'h8000_0000;
			3: pick_value = 32'h7FFF_FFFF;
			4: pick_value = $urandom_range(0, 7);
			5: pick_value = 32'hFFFF_FFF8 | $urandom_range(0, 7);
			default: pick_value = $urandom;
		endcase
	endfunction

	// Random runs: mostly short, some medium, a few that fill the store
	task automatic send_random_runs(input int n_items);
		int   sent;
		int   len;
		int   k;
		int   pick;
		logic mark;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				len = MAX_ITEMS;
			end else if (pick < 16) begin
				len = $urandom_range(13, 40);
			end else begin
				len = $urandom_range(1, 12);
			end
			// A full run may or may not carry the mark on its final item
			mark = (len == MAX_ITEMS) ? 1'($urandom_range(0, 1)) : 1'b1;
			for (k = 0; k < len; k++) begin
				send_value(pick_value(), (k == len - 1) ? mark : 1'b0);
			end
			sent += len;
		end
	endtask

	// One phase: set idle pattern and mode, send random runs, drain
	task automatic run_phase(input int s_pct, input int r_pct, input logic [31:0] mode_word,
		input int n_items, input logic with_hold);
		send_idle_pct  = s_pct;
		recv_stall_pct = r_pct;
		write_reg(REG_COMPARE_SIGNED, mode_word);
		pressure_req = with_hold;
		send_random_runs(n_items);
		wait_idle();
	endtask

	initial begin
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		in_valid      <= 1'b0;
		element_value <= '0;
		is_last       <= 1'b0;
		items_sent     = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		pressure_req   = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, signed compare: single value, extremes, equal values
		write_reg(REG_COMPARE_SIGNED, 32'd1);
		send_value(32'h8000_0000, 1'b1);
		send_extremes_run();
		send_value(32'd9, 1'b0);
		send_value(32'd5, 1'b0);
		send_value(32'd9, 1'b0);
		send_value(32'd5, 1'b1);
		wait_idle();

		// Directed, unsigned compare: upper bits set, then a write to an unused address
		write_reg(REG_COMPARE_SIGNED, 32'hFFFF_FFFE);
		write_reg(ADDR_UNUSED, 32'h0000_0001);
		send_extremes_run();
		send_value(32'hFFFF_FFFF, 1'b1);
		wait_idle();

		// Random phases over the idle patterns; long output hold-off in the third
		run_phase(0, 0, 32'd1, 110, 1'b0);
		run_phase(54, 0, 32'd0, 110, 1'b0);
		run_phase(0, 54, 32'd1, 110, 1'b1);
		run_phase(9, 9, 32'd0, 120, 1'b0);

		$display("Sent %0d items in %0d runs, checked %0d sorted results",
			items_sent, runs_seen, results_seen);
		$display("Covered signed and unsigned order, full store, and a %0d-cycle output hold-off",
			HOLD_CYCLES);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

>>> selection_sort_integer_top.f
rtl/ssi_pkg.sv
rtl/selection_sort_integer_top.sv
tb/selection_sort_integer_checker.sv
tb/selection_sort_integer_top_tb.sv
